FILE: hdl/bb_pkg.sv
// ----------------------------------------------------------------------------
// bb_pkg: shared types and constants of the box blur
// Frame limits, line store geometry and the words passed between the parts.
// ----------------------------------------------------------------------------
package bb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 7;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int RAD_W  = 3;
  // Ring of rows in the line store, rounded up to a power of two.
  localparam int RING_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int DIM_W  = $clog2(2 * MAX_RADIUS + 2);
  localparam int CNT_W  = 2 * DIM_W;
  localparam int SUM_W  = 8 + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int ADDR_W = RING_W + COL_W;

  // Configuration port.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic [10:0]      WIDTH_RST  = 11'd640;
  localparam logic [12:0]      HEIGHT_RST = 13'd480;
  localparam logic [RAD_W-1:0] RADIUS_RST = 3'd1;

  localparam logic ACT_PIXEL = 1'b0;

  // One pending output position.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } job_t;

  // Effective frame geometry, sizes held minus one.
  typedef struct packed {
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [RAD_W-1:0] rad;
  } geom_t;

  // Line store write request.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [23:0]       data;
  } wr_t;

endpackage

FILE: hdl/bb_front.sv
// ----------------------------------------------------------------------------
// bb_front: input side of the box blur
// Holds the configuration, stores pixels, tracks positions and decides which
// output windows are complete, queuing one job per released output.
// ----------------------------------------------------------------------------
module bb_front import bb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [7:0]           in_ch0,
  input  logic [7:0]           in_ch1,
  input  logic [7:0]           in_ch2,
  input  logic                 q_full,
  input  logic                 pending,
  output logic                 job_push,
  output job_t                 job,
  output wr_t                  wr,
  output geom_t                geom
);

  logic [10:0]      width_r;
  logic [12:0]      height_r;
  logic [RAD_W-1:0] radius_r;
  logic [COL_W-1:0] in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic             in_full_r;

  logic             accept, store, ready, last;
  logic [COL_W-1:0] ic_n, nc;
  logic [ROW_W-1:0] ir_n, nr;
  logic             full_n;
  logic [ROW_W:0]   nr_sum;
  logic [COL_W:0]   nc_sum;

  // Effective geometry after clamping.
  always_comb begin
    if (width_r == 11'd0) geom.wm1 = '0;
    else if (width_r > 11'(MAX_WIDTH)) geom.wm1 = COL_W'(MAX_WIDTH - 1);
    else geom.wm1 = COL_W'(width_r - 11'd1);
    if (height_r == 13'd0) geom.hm1 = '0;
    else if (height_r > 13'(MAX_HEIGHT)) geom.hm1 = ROW_W'(MAX_HEIGHT - 1);
    else geom.hm1 = ROW_W'(height_r - 13'd1);
    geom.rad = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
  end

  // A stored pixel waits until no window is in work, so it cannot
  // overwrite a row that a queued job still reads.
  assign store    = (in_action == ACT_PIXEL) && !in_full_r;
  assign in_stall = q_full || (store && pending);
  assign accept   = in_valid && !in_stall;

  // Input position after this word.
  always_comb begin
    ic_n   = in_col_r;
    ir_n   = in_row_r;
    full_n = in_full_r;
    if (store) begin
      if (in_col_r == geom.wm1) begin
        ic_n = '0;
        if (in_row_r == geom.hm1) begin
          ir_n   = '0;
          full_n = 1'b1;
        end else begin
          ir_n = in_row_r + ROW_W'(1);
        end
      end else begin
        ic_n = in_col_r + COL_W'(1);
      end
    end
  end

  // Window of the next output is complete once its lower right corner is in.
  always_comb begin
    nr_sum = {1'b0, out_row_r} + (ROW_W+1)'(geom.rad);
    nc_sum = {1'b0, out_col_r} + (COL_W+1)'(geom.rad);
    nr = (nr_sum > {1'b0, geom.hm1}) ? geom.hm1 : nr_sum[ROW_W-1:0];
    nc = (nc_sum > {1'b0, geom.wm1}) ? geom.wm1 : nc_sum[COL_W-1:0];
    ready = full_n || (nr < ir_n) || ((nr == ir_n) && (nc < ic_n));
    last  = (out_row_r == geom.hm1) && (out_col_r == geom.wm1);
  end

  assign job_push = accept && ready;
  assign job.row  = out_row_r;
  assign job.col  = out_col_r;
  assign job.last = last;

  assign wr.en   = accept && store;
  assign wr.addr = {in_row_r[RING_W-1:0], in_col_r};
  assign wr.data = {in_ch2, in_ch1, in_ch0};

  // Configuration and position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      radius_r  <= RADIUS_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      in_full_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[10:0];
        CFG_HEIGHT: height_r <= cfg_wdata;
        CFG_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
      if (cfg_index != CFG_WIDTH && cfg_index != CFG_HEIGHT &&
          cfg_index != CFG_RADIUS) begin
        in_full_r <= in_full_r;
      end else begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        in_full_r <= 1'b0;
      end
    end else if (accept) begin
      if (job_push && last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        in_full_r <= 1'b0;
      end else begin
        in_col_r  <= ic_n;
        in_row_r  <= ir_n;
        in_full_r <= full_n;
        if (job_push) begin
          if (out_col_r == geom.wm1) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + ROW_W'(1);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  // A pixel is only written while no window is in work.
  assert property (@(posedge clk) disable iff (!rst_n) wr.en |-> !pending)
    else $error("line store written while a window is in work");
  // The output position never runs ahead of the frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_row_r <= geom.hm1) || $past(cfg_we))
    else $error("output row beyond frame");

endmodule

FILE: hdl/bb_jobq.sv
// ----------------------------------------------------------------------------
// bb_jobq: two-entry job queue
// Parts the position tracking from the window arithmetic.
// ----------------------------------------------------------------------------
module bb_jobq import bb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("job queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("job queue underflow");

endmodule

FILE: hdl/bb_back.sv
// ----------------------------------------------------------------------------
// bb_back: window arithmetic of the box blur
// Owns the line store, sums one window pixel per cycle, divides the three
// sums by the pixel count bit by bit and holds the result word.
// ----------------------------------------------------------------------------
module bb_back import bb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  geom_t      geom,
  input  wr_t        wr,
  input  job_t       job,
  input  logic       q_empty,
  output logic       pop,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_ch0,
  output logic [7:0] out_ch1,
  output logic [7:0] out_ch2,
  output logic       out_frame_done
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [23:0] mem [2**ADDR_W];
  logic [23:0] rdata_r;
  logic        rd_vld_r;

  logic [2:0]        state_r, state_nxt;
  logic [ROW_W-1:0]  r0_r, r1_r, y_r, r0_nxt, r1_nxt, y_nxt;
  logic [COL_W-1:0]  c0_r, c1_r, x_r, c0_nxt, c1_nxt, x_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [SUM_W-1:0]  sum_r [3];
  logic [SUM_W-1:0]  sum_nxt [3];
  logic [CNT_W-1:0]  rem_r [3];
  logic [CNT_W-1:0]  rem_nxt [3];
  logic [CNT_W:0]    trial [3];
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        och_r [3];
  logic              odone_r;
  logic              load_out;

  logic [ROW_W:0]    rs;
  logic [COL_W:0]    cs;
  logic [DIM_W-1:0]  rows, cols;

  assign busy     = (state_r != ST_IDLE);
  assign pop      = (state_r == ST_IDLE) && !q_empty;
  assign load_out = (state_r == ST_HOLD) && (!out_valid_r || !out_stall);

  // Line store: one write port from the input side, one read port here.
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rdata_r <= mem[{y_r[RING_W-1:0], x_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= (state_r == ST_SUM);
  end

  // Window bounds of the head job, clipped to the frame.
  always_comb begin
    rs = {1'b0, job.row} + (ROW_W+1)'(geom.rad);
    cs = {1'b0, job.col} + (COL_W+1)'(geom.rad);
    r0_nxt = (job.row >= ROW_W'(geom.rad)) ? job.row - ROW_W'(geom.rad) : '0;
    c0_nxt = (job.col >= COL_W'(geom.rad)) ? job.col - COL_W'(geom.rad) : '0;
    r1_nxt = (rs > {1'b0, geom.hm1}) ? geom.hm1 : rs[ROW_W-1:0];
    c1_nxt = (cs > {1'b0, geom.wm1}) ? geom.wm1 : cs[COL_W-1:0];
    rows = DIM_W'(r1_r - r0_r) + DIM_W'(1);
    cols = DIM_W'(c1_r - c0_r) + DIM_W'(1);
  end

  // Sequencer: sum the window, divide, hand over the result.
  always_comb begin
    state_nxt     = state_r;
    y_nxt         = y_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    n_nxt         = n_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = sum_r[c];
      rem_nxt[c] = rem_r[c];
      trial[c]   = {rem_r[c], sum_r[c][SUM_W-1]} - {1'b0, n_r};
      if (rd_vld_r) sum_nxt[c] = sum_r[c] + SUM_W'(rdata_r[8*c +: 8]);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          y_nxt    = r0_nxt;
          x_nxt    = c0_nxt;
          last_nxt = job.last;
          for (int c = 0; c < 3; c++) sum_nxt[c] = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (x_r == c1_r) begin
          x_nxt = c0_r;
          if (y_r == r1_r) state_nxt = ST_FLUSH;
          else y_nxt = y_r + ROW_W'(1);
        end else begin
          x_nxt = x_r + COL_W'(1);
        end
      end
      ST_FLUSH: begin
        n_nxt    = CNT_W'(rows) * CNT_W'(cols);
        dcnt_nxt = '0;
        for (int c = 0; c < 3; c++) rem_nxt[c] = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle, shifted into the sum register.
        for (int c = 0; c < 3; c++) begin
          if (!trial[c][CNT_W]) begin
            rem_nxt[c] = trial[c][CNT_W-1:0];
            sum_nxt[c] = {sum_r[c][SUM_W-2:0], 1'b1};
          end else begin
            rem_nxt[c] = {rem_r[c][CNT_W-2:0], sum_r[c][SUM_W-1]};
            sum_nxt[c] = {sum_r[c][SUM_W-2:0], 1'b0};
          end
        end
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(SUM_W - 1)) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      r0_r <= r0_nxt;
      r1_r <= r1_nxt;
      c0_r <= c0_nxt;
      c1_r <= c1_nxt;
    end
    y_r    <= y_nxt;
    x_r    <= x_nxt;
    last_r <= last_nxt;
    n_r    <= n_nxt;
    dcnt_r <= dcnt_nxt;
    for (int c = 0; c < 3; c++) begin
      sum_r[c] <= sum_nxt[c];
      rem_r[c] <= rem_nxt[c];
    end
    if (load_out) begin
      for (int c = 0; c < 3; c++) och_r[c] <= sum_r[c][7:0];
      odone_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ch0        = och_r[0];
  assign out_ch1        = och_r[1];
  assign out_ch2        = och_r[2];
  assign out_frame_done = odone_r;

  // The divider only starts from a freshly flushed window.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && $past(state_r) != ST_DIV) |-> $past(state_r) == ST_FLUSH)
    else $error("divide entered without a flushed sum");
  // A finished division has used every quotient bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> (dcnt_r == DCNT_W'(SUM_W)) || (dcnt_r == '0))
    else $error("divide left early");
  // The divisor is never zero while dividing.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_DIV) |-> n_r != '0)
    else $error("window count is zero");

endmodule

FILE: hdl/box_blur_rgb_clipped.sv
// ----------------------------------------------------------------------------
// box_blur_rgb_clipped: per-channel box blur of a three-byte pixel stream
// Line store, window sums and truncating means with frame-edge clipping.
// ----------------------------------------------------------------------------
// Pixels come in raster order and each output word is the per-channel mean
// over a (2R+1)x(2R+1) window clipped to the frame, released in raster order
// once its window is in; drain words (and pixels after the frame is complete)
// release pending outputs. For each output the back end does one line store
// read per window pixel, then runs a one bit per cycle divider. A pixel
// word is held off while a window is still in work, so pixels and outputs
// alternate; drain words queue two deep ahead of the arithmetic. A write to
// the width, height or radius index restarts the frame.
// ----------------------------------------------------------------------------
module box_blur_rgb_clipped import bb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [7:0]           in_ch0,
  input  logic [7:0]           in_ch1,
  input  logic [7:0]           in_ch2,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_ch0,
  output logic [7:0]           out_ch1,
  output logic [7:0]           out_ch2,
  output logic                 out_frame_done
);

  job_t  push_job, head;
  wr_t   wr;
  geom_t geom;
  logic  job_push, q_full, q_empty, pop, back_busy, pending;

  assign pending = back_busy || !q_empty;

  // Position tracking and pixel writes.
  bb_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_action, .in_ch0, .in_ch1, .in_ch2,
    .q_full, .pending, .job_push, .job(push_job), .wr, .geom
  );

  // Queue of released output positions.
  bb_jobq u_jobq (
    .clk, .rst_n, .push(job_push), .push_job, .pop, .head,
    .full(q_full), .empty(q_empty)
  );

  // Window sums and division.
  bb_back u_back (
    .clk, .rst_n, .geom, .wr, .job(head), .q_empty, .pop, .busy(back_busy),
    .out_valid, .out_stall, .out_ch0, .out_ch1, .out_ch2, .out_frame_done
  );

endmodule

FILE: verif/box_blur_rgb_clipped_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_rgb_clipped_chk: result checker of the box blur
// Watches the configuration port and both channels, predicts every output
// word from its own copy of the line store and frame positions, and compares.
// ----------------------------------------------------------------------------
module box_blur_rgb_clipped_chk import bb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_action,
  input  logic [7:0]           in_ch0,
  input  logic [7:0]           in_ch1,
  input  logic [7:0]           in_ch2,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_ch0,
  input  logic [7:0]           out_ch1,
  input  logic [7:0]           out_ch2,
  input  logic                 out_frame_done,
  output int                   errors,
  output int                   pending,
  output int                   frames
);

  localparam int RING = 2 * MAX_RADIUS + 2;

  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       done;
  } blur_px_t;

  logic [23:0] line_mem [RING * MAX_WIDTH];
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [2:0]  radius_reg;
  int          in_col, in_row, out_col, out_row;
  bit          in_full;
  blur_px_t    blur_q[$];

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  task automatic restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    in_full = 0;
    blur_q.delete();
  endtask

  // Predict the word (if any) that one accepted input word releases.
  task automatic blur_accept(logic act, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    int w, h, r, r0, r1, c0, c1, n, s0, s1, s2;
    bit ready;
    logic [23:0] p;
    blur_px_t e;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    if (act == ACT_PIXEL && !in_full) begin
      line_mem[(in_row % RING) * MAX_WIDTH + in_col] = {b2, b1, b0};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          in_full = 1;
        end
      end
    end
    r1 = (out_row + r > h - 1) ? h - 1 : out_row + r;
    c1 = (out_col + r > w - 1) ? w - 1 : out_col + r;
    ready = in_full || (r1 * w + c1 < in_row * w + in_col);
    if (!ready) return;
    r0 = (out_row >= r) ? out_row - r : 0;
    c0 = (out_col >= r) ? out_col - r : 0;
    s0 = 0; s1 = 0; s2 = 0;
    for (int y = r0; y <= r1; y++) begin
      for (int x = c0; x <= c1; x++) begin
        p = line_mem[(y % RING) * MAX_WIDTH + x];
        s0 += p[7:0];
        s1 += p[15:8];
        s2 += p[23:16];
      end
    end
    n = (r1 - r0 + 1) * (c1 - c0 + 1);
    e.ch0  = 8'(s0 / n);
    e.ch1  = 8'(s1 / n);
    e.ch2  = 8'(s2 / n);
    e.done = (out_row == h - 1) && (out_col == w - 1);
    blur_q.push_back(e);
    if (e.done) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      in_full = 0;
      frames++;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // Compare one delivered word with the oldest prediction.
  task automatic blur_compare();
    blur_px_t e;
    if (blur_q.size() == 0) begin
      report_mismatch("unexpected output word", 1, 0);
      return;
    end
    e = blur_q.pop_front();
    if (out_ch0 !== e.ch0) report_mismatch("out_ch0", out_ch0, e.ch0);
    if (out_ch1 !== e.ch1) report_mismatch("out_ch1", out_ch1, e.ch1);
    if (out_ch2 !== e.ch2) report_mismatch("out_ch2", out_ch2, e.ch2);
    if (out_frame_done !== e.done) report_mismatch("out_frame_done", out_frame_done, e.done);
  endtask

  initial begin
    errors = 0;
    frames = 0;
    pending = 0;
  end

  // Track registers, inputs and outputs at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      radius_reg = RADIUS_RST;
      restart_frame();
    end else begin
      if (out_valid && !out_stall) blur_compare();
      if (cfg_we) begin
        // Writes to an unused index leave the frame running.
        case (cfg_index)
          CFG_WIDTH: begin
            width_reg = cfg_wdata[10:0];
            restart_frame();
          end
          CFG_HEIGHT: begin
            height_reg = cfg_wdata[12:0];
            restart_frame();
          end
          CFG_RADIUS: begin
            radius_reg = cfg_wdata[2:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) blur_accept(in_action, in_ch0, in_ch1, in_ch2);
    end
    pending <= blur_q.size();
  end

endmodule

FILE: verif/box_blur_rgb_clipped_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_rgb_clipped_tb: testbench of the box blur
// Runs directed and random frames of many sizes and radii, with pixel and
// drain words, random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module box_blur_rgb_clipped_tb;
  import bb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic ACT_DRAIN = 1'b1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid, in_stall, in_action;
  logic [7:0]           in_ch0, in_ch1, in_ch2;
  logic                 out_valid, out_stall;
  logic [7:0]           out_ch0, out_ch1, out_ch2;
  logic                 out_frame_done;
  int                   errors, pending, frames;

  int  idle_mode;
  int  words_sent;
  bit  hold_req, hold_on;

  box_blur_rgb_clipped uut (.*);

  box_blur_rgb_clipped_chk chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stalls per phase, plus one long hold-off.
  always @(posedge clk) begin
    if (hold_on) out_stall <= 1'b1;
    else if (idle_mode == 2) out_stall <= ($urandom_range(0, 99) < 61);
    else if (idle_mode == 3) out_stall <= ($urandom_range(0, 99) < 18);
    else out_stall <= 1'b0;
  end

  initial begin
    hold_on = 0;
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1;
    repeat (700) @(posedge clk);
    hold_on <= 0;
  end

  // Send one word and wait until the block takes it.
  task automatic send_word(logic act, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    while ((idle_mode == 1 && $urandom_range(0, 99) < 61) ||
           (idle_mode == 3 && $urandom_range(0, 99) < 18)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_ch0    <= b0;
    in_ch1    <= b1;
    in_ch2    <= b2;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Wait until nothing is expected and the back end has settled.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Configure a frame, then feed it; extreme bytes when asked. A limit
  // above zero stops the frame early, leaving it unfinished.
  task automatic run_frame(logic [CFG_W-1:0] w_val, logic [CFG_W-1:0] h_val,
                           logic [CFG_W-1:0] r_val, bit extremes, int limit);
    int w, h, n, pix, f0, cnt;
    logic act;
    logic [7:0] b0, b1, b2;
    settle();
    write_reg(CFG_RADIUS, r_val);
    write_reg(CFG_WIDTH, w_val);
    write_reg(CFG_HEIGHT, h_val);
    w = (w_val[10:0] == 0) ? 1 : (w_val[10:0] > MAX_WIDTH) ? MAX_WIDTH : int'(w_val[10:0]);
    h = (h_val == 0) ? 1 : (h_val > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_val);
    n = w * h;
    pix = 0;
    cnt = 0;
    @(posedge clk);
    f0 = frames;
    while (frames == f0 && (limit == 0 || cnt < limit)) begin
      // Mostly pixels until the frame is in, then mostly drains.
      if (pix < n) act = ($urandom_range(0, 4) == 0) ? ACT_DRAIN : ACT_PIXEL;
      else act = ($urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_DRAIN;
      if (extremes) begin
        b0 = {8{$urandom_range(0, 1) == 1}};
        b1 = {8{$urandom_range(0, 1) == 1}};
        b2 = {8{$urandom_range(0, 1) == 1}};
      end else begin
        b0 = 8'($urandom); b1 = 8'($urandom); b2 = 8'($urandom);
      end
      send_word(act, b0, b1, b2);
      if (act == ACT_PIXEL) pix++;
      cnt++;
    end
  endtask

  initial begin
    int k;
    logic [CFG_W-1:0] wv, hv, rv;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_action <= ACT_PIXEL;
    in_ch0    <= '0;
    in_ch1    <= '0;
    in_ch2    <= '0;
    idle_mode  = 0;
    words_sent = 0;
    hold_req   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: extreme bytes, zero sizes, radius wider than the frame.
    write_reg(CFG_UNUSED, '1);
    run_frame(13'd3, 13'd2, 13'd0, 1, 0);
    run_frame(13'd0, 13'd0, 13'd7, 1, 0);
    run_frame(13'h1805, 13'd2, 13'h1ff9, 1, 0);
    run_frame(13'd1, 13'd4, 13'd1, 0, 0);

    // Long output hold-off on a larger frame with a steady sender.
    hold_req = 1;
    run_frame(13'd16, 13'd10, 13'd1, 0, 0);

    // Random frames, rotating through the idling modes.
    k = 0;
    while (words_sent < 1450) begin
      idle_mode = k % 4;
      wv = 13'($urandom_range(1, 12) | ($urandom_range(0, 3) << 11));
      hv = 13'($urandom_range(1, 8));
      rv = 13'($urandom_range(0, 7) | ($urandom_range(0, 1023) << 3));
      if ($urandom_range(0, 15) == 0) wv = 13'd0;
      if ($urandom_range(0, 15) == 0) hv = 13'd0;
      if (k == 6) begin
        wv = 13'd2047; hv = 13'd1; rv = 13'd7;
        run_frame(wv, hv, rv, 0, 0);
      end else if (k == 11) begin
        wv = 13'd1; hv = 13'h1fff; rv = 13'd2;
        run_frame(wv, hv, rv, 0, 120);
      end else begin
        run_frame(wv, hv, rv, $urandom_range(0, 7) == 0, 0);
      end
      k++;
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
